>>> src/kts_pkg.sv
// Package for the keyed tone synthesizer core.
// Holds the note pitch table, Q30 constants, operation codes and the pipeline control type.
// No dependencies.
package kts_pkg;

  localparam int NUM_KEYS = 12;
  localparam int KEY_W = 4;
  localparam int LEVEL_W = 4;

  // Note pitches in hertz, key 0 up to key 11
  localparam int unsigned PITCH_HZ [NUM_KEYS] = '{
    131, 139, 147, 156, 165, 175, 185, 196, 208, 220, 233, 247
  };

  // Q30 fixed point
  localparam longint unsigned ONE_Q30 = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Sine magnitude width (values up to about 1.0 in Q30) and signed sine width
  localparam int SIN_MAG_W = 31;
  localparam int SIN_W = SIN_MAG_W + 1;

  // Operation codes
  localparam logic OP_KEYS = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Highest volume in twelfths
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 4'd12;

  // Control that travels with a tick through the sample pipeline
  typedef struct packed {
    logic               harm;
    logic               two;
    logic               snd;
    logic [LEVEL_W-1:0] lvl;
  } ctrl_t;

endpackage

>>> src/keyed_tone_synthesizer_core.sv
// Keyed tone synthesizer core: twelve-key dual-tone DDS with a three-harmonic mode.
// A tick transaction's sample passes all ten sample stages to the output register.
// Throughput: one transaction per cycle unless in_stall; a key transaction gives no result.
// in_stall rises only when all ten sample stages are full and out_stall holds the output.
// Reset (rst, synchronous): clears mode, phases, key state and all stage valid bits.
// Depends on kts_pkg.
module keyed_tone_synthesizer_core
  import kts_pkg::*;
#(
  parameter int TABLE_DEPTH    = 128,
  parameter int PHASE_BITS     = 24,
  parameter int DAC_BITS       = 12,
  parameter int SAMPLE_RATE_HZ = 48000
) (
  input  logic                clk,
  input  logic                rst,
  // configuration
  input  logic                cfg_write_en,
  input  logic                cfg_write_data,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                operation,
  input  logic [11:0]         key_mask,
  input  logic [LEVEL_W-1:0]  amp_level,
  // output channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [DAC_BITS-1:0] dac_value,
  output logic                two_tone
);

  // ---------------------------------------------------------------------------
  // Derived sizes and constants
  // ---------------------------------------------------------------------------
  localparam int NST   = 10;                       // sample pipeline stages
  localparam int PB    = PHASE_BITS;
  localparam int IDXW  = $clog2(TABLE_DEPTH);
  localparam int PRODW = PB + IDXW + 1;
  localparam int KW    = IDXW + 2;                 // holds 4k and 3k

  // Quarter-wave offsets are multiples of this step, so the table is sampled with it
  localparam int GSTEP = (TABLE_DEPTH % 4 == 0) ? 4 : ((TABLE_DEPTH % 2 == 0) ? 2 : 1);
  localparam int GSH   = $clog2(GSTEP);
  localparam int TSIZE = TABLE_DEPTH / GSTEP + 1;
  localparam int TABW  = $clog2(TSIZE);

  localparam logic [KW-1:0] D1 = KW'(TABLE_DEPTH);
  localparam logic [KW-1:0] D2 = KW'(2 * TABLE_DEPTH);
  localparam logic [KW-1:0] D3 = KW'(3 * TABLE_DEPTH);

  localparam int MIX_W = 34;
  localparam logic signed [MIX_W-1:0] MIX_ONE   = MIX_W'(ONE_Q30);
  localparam logic signed [MIX_W-1:0] MIX_TWO   = MIX_W'(2 * ONE_Q30);
  localparam logic signed [MIX_W-1:0] MIX_THREE = MIX_W'(3 * ONE_Q30);

  localparam int V_W  = 31;
  localparam logic [V_W-1:0] V_ONE = V_W'(ONE_Q30);
  localparam longint unsigned DIV3_32 = 64'hAAAAAAAB;  // ceil(2^33 / 3)

  localparam int VL_W = V_W + LEVEL_W;
  localparam int XW   = VL_W + DAC_BITS + 1;
  localparam int TW   = DAC_BITS + 2;
  localparam int QW   = 2 * TW + 1;
  localparam logic [DAC_BITS-1:0] DAC_FULL = {DAC_BITS{1'b1}};
  localparam longint unsigned ROUND_BIAS = 64'd6442450944;     // 6 * 2^30
  localparam longint unsigned DIV3_T = ((64'd1 << (TW + 1)) + 64'd2) / 64'd3;

  // ---------------------------------------------------------------------------
  // Constant tables
  // ---------------------------------------------------------------------------
  // Sine magnitude over a quarter wave: truncated eight-term Taylor series in Q30
  function automatic logic [SIN_MAG_W-1:0] sine_mag(input int unsigned rem);
    logic [63:0] x, x2, term, sum;
    x    = (HALF_PI_Q30 * 64'(rem)) / 64'(TABLE_DEPTH);
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - term;
    return sum[SIN_MAG_W-1:0];
  endfunction

  // Phase increment of a note: rounded hz * 2^PB / sample rate
  function automatic logic [PB-1:0] phase_step(input int unsigned hz);
    logic [63:0] acc;
    acc = ((64'(hz) << PB) + 64'(SAMPLE_RATE_HZ / 2)) / 64'(SAMPLE_RATE_HZ);
    return acc[PB-1:0];
  endfunction

  logic [SIN_MAG_W-1:0] sin_tab  [TSIZE];
  logic [PB-1:0]        step_tab [NUM_KEYS];

  for (genvar g = 0; g < TSIZE; g++) begin : g_sin_tab
    assign sin_tab[g] = sine_mag(g * GSTEP);
  end

  for (genvar g = 0; g < NUM_KEYS; g++) begin : g_step_tab
    assign step_tab[g] = phase_step(PITCH_HZ[g]);
  end

  // ---------------------------------------------------------------------------
  // Handshake and stage advance
  // ---------------------------------------------------------------------------
  logic [NST-1:0] vld;
  logic [NST-1:0] en;
  logic           in_acc;
  logic           tick_acc;
  logic           key_acc;

  // A stage advances when it is empty or the stage after it advances
  always_comb begin
    en[NST-1] = !vld[NST-1] || !out_stall;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_stall = !en[0];
  assign in_acc   = in_valid && !in_stall;
  assign tick_acc = in_acc && (operation == OP_TICK);
  assign key_acc  = in_acc && (operation == OP_KEYS);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= tick_acc;
      end
      for (int i = 1; i < NST; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Mode register and key / phase state
  // ---------------------------------------------------------------------------
  logic             harmonic_mode;
  logic [PB-1:0]    phase_first;
  logic [PB-1:0]    phase_second;
  logic [KEY_W-1:0] key_high;
  logic [KEY_W-1:0] key_low;
  logic             dual_keys;
  logic             sounding;

  logic [KEY_W-1:0] scan_high;
  logic [KEY_W-1:0] scan_low;
  logic             scan_dual;
  logic             two_now;

  // Lowest and highest pressed key of the incoming mask
  always_comb begin
    scan_high = '0;
    scan_low  = '0;
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      if (key_mask[i]) scan_low = KEY_W'(i);
    end
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (key_mask[i]) scan_high = KEY_W'(i);
    end
  end

  // Two or more keys down: clearing the lowest set bit leaves something
  assign scan_dual = (key_mask & (key_mask - 12'd1)) != 12'd0;

  // Second tone mixes in only in normal mode with two keys down
  assign two_now = !harmonic_mode && dual_keys && sounding;

  always_ff @(posedge clk) begin
    if (rst) begin
      harmonic_mode <= 1'b0;
      phase_first   <= '0;
      phase_second  <= '0;
      key_high      <= '0;
      key_low       <= '0;
      dual_keys     <= 1'b0;
      sounding      <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        harmonic_mode <= cfg_write_data;
      end
      if (key_acc) begin
        // New chord: latch keys and restart both oscillators
        key_high     <= scan_high;
        key_low      <= scan_low;
        dual_keys    <= scan_dual;
        sounding     <= |key_mask;
        phase_first  <= '0;
        phase_second <= '0;
      end else if (tick_acc && sounding) begin
        // Advance after the sample has taken the current phase
        phase_first <= phase_first + step_tab[key_high];
        if (two_now) begin
          phase_second <= phase_second + step_tab[key_low];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: snapshot of phases and control for this tick
  // ---------------------------------------------------------------------------
  logic [PB-1:0]    s1_ph1;
  logic [PB-1:0]    s1_ph2;
  ctrl_t            s1_c;
  logic [LEVEL_W-1:0] lvl_sat;

  // Saturate volume above twelve
  assign lvl_sat = (amp_level > LEVEL_MAX) ? LEVEL_MAX : amp_level;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_ph1    <= phase_first;
      s1_ph2    <= phase_second;
      s1_c.harm <= harmonic_mode;
      s1_c.two  <= two_now;
      s1_c.snd  <= sounding;
      s1_c.lvl  <= lvl_sat;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: table index = phase * depth >> PB
  // ---------------------------------------------------------------------------
  logic [PRODW-1:0] prod1;
  logic [PRODW-1:0] prod2;
  logic [IDXW-1:0]  s2_idx1;
  logic [IDXW-1:0]  s2_idx2;
  ctrl_t            s2_c;

  assign prod1 = PRODW'(s1_ph1) * PRODW'(TABLE_DEPTH);
  assign prod2 = PRODW'(s1_ph2) * PRODW'(TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_idx1 <= prod1[PB +: IDXW];
      s2_idx2 <= prod2[PB +: IDXW];
      s2_c    <= s1_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: pick the three lookups (2k and 3k wrap modulo the depth)
  // ---------------------------------------------------------------------------
  logic [KW-1:0]   dbl;
  logic [KW-1:0]   trp;
  logic [KW-1:0]   k2;
  logic [KW-1:0]   k3;
  logic [IDXW-1:0] s3_k [3];
  ctrl_t           s3_c;

  assign dbl = KW'(s2_idx1) << 1;
  assign trp = dbl + KW'(s2_idx1);
  assign k2  = (dbl >= D1) ? (dbl - D1) : dbl;
  assign k3  = (trp >= D2) ? (trp - D2) : ((trp >= D1) ? (trp - D1) : trp);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_k[0] <= s2_idx1;
      s3_k[1] <= s2_c.harm ? k2[IDXW-1:0] : s2_idx2;
      s3_k[2] <= k3[IDXW-1:0];
      s3_c    <= s2_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: quadrant decode and quarter-wave mirror
  // ---------------------------------------------------------------------------
  logic [KW-1:0]   q4   [3];
  logic [1:0]      quad [3];
  logic [KW-1:0]   rem  [3];
  logic [KW-1:0]   rmir [3];
  logic [TABW-1:0] s4_tidx [3];
  logic            s4_neg  [3];
  ctrl_t           s4_c;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      q4[l] = {s3_k[l], 2'b00};
      if (q4[l] >= D3) begin
        quad[l] = 2'd3;
        rem[l]  = q4[l] - D3;
      end else if (q4[l] >= D2) begin
        quad[l] = 2'd2;
        rem[l]  = q4[l] - D2;
      end else if (q4[l] >= D1) begin
        quad[l] = 2'd1;
        rem[l]  = q4[l] - D1;
      end else begin
        quad[l] = 2'd0;
        rem[l]  = q4[l];
      end
      // Odd quadrants run the quarter wave backward
      rmir[l] = quad[l][0] ? (D1 - rem[l]) : rem[l];
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int l = 0; l < 3; l++) begin
        s4_tidx[l] <= TABW'(rmir[l] >> GSH);
        s4_neg[l]  <= quad[l][1];
      end
      s4_c <= s3_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: signed sines from the table
  // ---------------------------------------------------------------------------
  logic signed [SIN_W-1:0] sin_pos [3];
  logic signed [SIN_W-1:0] s5_sin  [3];
  ctrl_t                   s5_c;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      sin_pos[l] = $signed({1'b0, sin_tab[s4_tidx[l]]});
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int l = 0; l < 3; l++) begin
        s5_sin[l] <= s4_neg[l] ? -sin_pos[l] : sin_pos[l];
      end
      s5_c <= s4_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: offset mix in Q30
  // ---------------------------------------------------------------------------
  logic signed [MIX_W-1:0] mix_sum;
  logic signed [MIX_W-1:0] s6_mix;
  ctrl_t                   s6_c;

  always_comb begin
    if (s5_c.harm) begin
      mix_sum = MIX_THREE + MIX_W'(s5_sin[0]) + MIX_W'(s5_sin[1]) + MIX_W'(s5_sin[2]);
    end else if (s5_c.two) begin
      mix_sum = MIX_TWO + MIX_W'(s5_sin[0]) + MIX_W'(s5_sin[1]);
    end else begin
      mix_sum = MIX_ONE + MIX_W'(s5_sin[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_mix <= mix_sum;
      s6_c   <= s5_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: divide by 2, 4 or 6, clamp to [0, 1.0]; silence forces zero
  // ---------------------------------------------------------------------------
  logic [MIX_W-2:0] mix_mag;
  logic [31:0]      y_half;
  logic [63:0]      quot3;
  logic [31:0]      v_sel;
  logic [V_W-1:0]   v_next;
  logic [V_W-1:0]   s7_v;
  ctrl_t            s7_c;

  always_comb begin
    mix_mag = s6_mix[MIX_W-1] ? '0 : s6_mix[MIX_W-2:0];
    y_half  = mix_mag[32:1];
    // Exact divide by three of a 32-bit value
    quot3   = (64'(y_half) * DIV3_32) >> 33;
    if (s6_c.harm) begin
      v_sel = quot3[31:0];
    end else if (s6_c.two) begin
      v_sel = 32'(mix_mag[32:2]);
    end else begin
      v_sel = y_half;
    end
    if (!s6_c.snd) begin
      v_next = '0;
    end else if (v_sel > 32'(V_ONE)) begin
      v_next = V_ONE;
    end else begin
      v_next = v_sel[V_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s7_v <= v_next;
      s7_c <= s6_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 8: apply volume
  // ---------------------------------------------------------------------------
  logic [VL_W-1:0] s8_vl;
  ctrl_t           s8_c;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s8_vl <= VL_W'(s7_v) * VL_W'(s7_c.lvl);
      s8_c  <= s7_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 9: scale to DAC range, round, divide by 2^32 (first part of 12 * 2^30)
  // ---------------------------------------------------------------------------
  logic [XW-1:0] scaled;
  logic [TW-1:0] s9_t;
  ctrl_t         s9_c;

  assign scaled = XW'(s8_vl) * XW'(DAC_FULL) + XW'(ROUND_BIAS);

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s9_t <= scaled[32 +: TW];
      s9_c <= s8_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 10: divide by three, clamp; this is the output register
  // ---------------------------------------------------------------------------
  logic [QW-1:0] q_full;
  logic [QW-1:0] q_div;

  assign q_full = QW'(s9_t) * QW'(DIV3_T);
  assign q_div  = q_full >> (TW + 1);

  always_ff @(posedge clk) begin
    if (en[9]) begin
      dac_value <= (q_div > QW'(DAC_FULL)) ? DAC_FULL : q_div[DAC_BITS-1:0];
      two_tone  <= s9_c.two;
    end
  end

  assign out_valid = vld[NST-1];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`ifndef ASSERT_OFF
  // Input holds off only when every stage is full and the output is held
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> ((&vld) && out_stall))
    else $error("input stalled while the sample pipeline has room");

  // A key transaction restarts both oscillators
  a_key_clears_phase: assert property (@(posedge clk) disable iff (rst)
    key_acc |=> (phase_first == '0) && (phase_second == '0))
    else $error("phases not cleared after key transaction");

  // Silent ticks leave the phase where it was
  a_silent_holds_phase: assert property (@(posedge clk) disable iff (rst)
    (tick_acc && !sounding) |=> (phase_first == $past(phase_first)))
    else $error("phase moved on a silent tick");

  // Two keys recorded implies distinct low and high keys
  a_dual_order: assert property (@(posedge clk) disable iff (rst)
    dual_keys |-> (key_low < key_high))
    else $error("dual keys with low key not below high key");
`endif

endmodule
